// File: design/tgp_pkg.sv
// Package for the tile grid to pixel position block: widths, register indexes,
// projection codes and the structs passed between its modules. No dependencies.
`default_nettype none

package tgp_pkg;

  localparam int COORD_BITS = 10;
  localparam int SIZE_W     = 10;
  localparam int OUT_W      = 22;
  localparam int OPA_W      = COORD_BITS + 2;
  localparam int OPB_W      = SIZE_W + 1;
  localparam int PROD_W     = OPA_W + OPB_W + 1;
  localparam int SUM_W      = (PROD_W > OUT_W) ? PROD_W + 1 : OUT_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [1:0] MODE_ORTHO = 2'd0;
  localparam logic [1:0] MODE_ISO   = 2'd1;
  localparam logic [1:0] MODE_STAG  = 2'd2;
  localparam logic [1:0] MODE_HEX   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic              axis;
    logic              parity;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [SIZE_W-1:0] side;
  } cfg_t;

  // One output coordinate is a * b + c.
  typedef struct packed {
    logic signed [OPA_W-1:0] a;
    logic [OPB_W-1:0]        b;
    logic [SIZE_W-1:0]       c;
  } term_t;

endpackage

`default_nettype wire

// File: design/tgp_operand_sel.sv
// Operand selection: turns a tile coordinate and the configuration into a
// multiply-add term for each axis. Depends on tgp_pkg.
`default_nettype none

module tgp_operand_sel (
  input  tgp_pkg::cfg_t                     cfg,
  input  logic [tgp_pkg::COORD_BITS-1:0]    tx,
  input  logic [tgp_pkg::COORD_BITS-1:0]    ty,
  output tgp_pkg::term_t                    term_x,
  output tgp_pkg::term_t                    term_y
);
  import tgp_pkg::*;

  logic signed [OPA_W-1:0] tx_one;
  logic signed [OPA_W-1:0] ty_one;
  logic signed [OPA_W-1:0] tx_two;
  logic signed [OPA_W-1:0] ty_two;
  logic [OPB_W-1:0]        w_ext;
  logic [OPB_W-1:0]        h_ext;
  logic [OPB_W-1:0]        w_hex;
  logic [OPB_W-1:0]        h_hex;
  logic                    row_shift;
  logic                    col_shift;

  assign tx_one    = $signed({2'b00, tx});
  assign ty_one    = $signed({2'b00, ty});
  assign tx_two    = $signed({1'b0, tx, 1'b0});
  assign ty_two    = $signed({1'b0, ty, 1'b0});
  assign w_ext     = {1'b0, cfg.width};
  assign h_ext     = {1'b0, cfg.height};
  assign w_hex     = w_ext + {1'b0, cfg.side};
  assign h_hex     = h_ext + {1'b0, cfg.side};
  assign row_shift = ty[0] != cfg.parity;
  assign col_shift = tx[0] != cfg.parity;

  always_comb begin
    term_x = '{a: tx_two, b: w_ext, c: '0};
    term_y = '{a: ty_two, b: h_ext, c: '0};
    unique case (cfg.mode) inside
      MODE_ORTHO: begin
      end
      MODE_ISO: begin
        term_x.a = tx_one - ty_one;
        term_y.a = tx_one + ty_one;
      end
      MODE_STAG, MODE_HEX: begin
        if (cfg.axis == 1'b0) begin
          term_x.c = row_shift ? cfg.width : '0;
          term_y.a = ty_one;
          term_y.b = (cfg.mode == MODE_HEX) ? h_hex : h_ext;
        end else begin
          term_y.c = col_shift ? cfg.height : '0;
          term_x.a = tx_one;
          term_x.b = (cfg.mode == MODE_HEX) ? w_hex : w_ext;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/tgp_mul_add.sv
// Multiply-add for one output axis: a * b + c, wrapped to the output width.
// Depends on tgp_pkg.
`default_nettype none

module tgp_mul_add (
  input  tgp_pkg::term_t                   term,
  output logic [tgp_pkg::OUT_W-1:0]        result
);
  import tgp_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  assign prod   = term.a * $signed({1'b0, term.b});
  assign sum    = SUM_W'(prod) + $signed(SUM_W'({1'b0, term.c}));
  assign result = sum[OUT_W-1:0];

endmodule

`default_nettype wire

// File: design/tile_grid_to_pixel_position.sv
// Top level of the tile grid to pixel position block: configuration registers,
// operand register and result register. Depends on tgp_pkg, tgp_operand_sel
// and tgp_mul_add.
//
//   Port group     Direction  Transfer
//   cfg_*          in         one register write at each edge with cfg_write high
//   start, tile_*  in         one tile at each edge with start high and busy low
//   done, pixel_*  out        one position, held for the single cycle that done is high
//
// A tile may be started in every cycle; busy is always low.
// Start is registered into op_valid and done is registered from op_valid, in step
// with the operand and result registers; the position is taken while done is high.
// The path from start to result is the operand register, then one multiplier
// and adder per axis feeding the result register.
// Reset clears the configuration and the valid flags; nothing stalls the block.
`default_nettype none

module tile_grid_to_pixel_position (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tgp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [tgp_pkg::COORD_BITS-1:0]     tile_x,
  input  logic [tgp_pkg::COORD_BITS-1:0]     tile_y,
  output logic                               done,
  output logic signed [tgp_pkg::OUT_W-1:0]   pixel_x_half,
  output logic signed [tgp_pkg::OUT_W-1:0]   pixel_y_half
);
  import tgp_pkg::*;

  cfg_t             cfg;
  term_t            sel_x;
  term_t            sel_y;
  term_t            op_x;
  term_t            op_y;
  logic             op_valid;
  logic [OUT_W-1:0] res_x;
  logic [OUT_W-1:0] res_y;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode   <= cfg_data[1:0];
        REG_AXIS:   cfg.axis   <= cfg_data[0];
        REG_PARITY: cfg.parity <= cfg_data[0];
        REG_WIDTH:  cfg.width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[SIZE_W-1:0];
        REG_SIDE:   cfg.side   <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tgp_operand_sel u_sel (
    .cfg    (cfg),
    .tx     (tile_x),
    .ty     (tile_y),
    .term_x (sel_x),
    .term_y (sel_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_x <= sel_x;
    op_y <= sel_y;
  end

  tgp_mul_add u_mul_x (
    .term   (op_x),
    .result (res_x)
  );

  tgp_mul_add u_mul_y (
    .term   (op_y),
    .result (res_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    pixel_x_half <= $signed(res_x);
    pixel_y_half <= $signed(res_y);
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for tile_grid_to_pixel_position: drives tiles under many projection settings and
// checks every position against an in-bench predictor of the four projections.
// Depends on tgp_pkg and the block's top level; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
  import tgp_pkg::*;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_CAP  = 100;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } tile_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } pos_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [COORD_BITS-1:0]         tile_x = '0;
  logic [COORD_BITS-1:0]         tile_y = '0;
  logic                          done;
  logic signed [OUT_W-1:0]       pixel_x_half;
  logic signed [OUT_W-1:0]       pixel_y_half;

  tile_t tiles_pending[$];
  pos_t  positions_due[$];
  cfg_t  regs = '0;
  int    idle_pct = 28;
  int    burst_left = 0;
  int    mismatches = 0;
  int    cycles = 0;

  tile_grid_to_pixel_position dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .done         (done),
    .pixel_x_half (pixel_x_half),
    .pixel_y_half (pixel_y_half)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint line_pos(longint idx, longint size, logic line_lsb,
                                      logic parity);
    longint v;
    v = 2 * idx * size;
    if (line_lsb != parity) v += size;
    return v;
  endfunction

  function automatic pos_t project(tile_t t, cfg_t c);
    longint tx, ty, w, h, s, px, py;
    pos_t   r;
    tx = t.x;
    ty = t.y;
    w  = c.width;
    h  = c.height;
    s  = c.side;
    case (c.mode)
      MODE_ORTHO: begin
        px = 2 * tx * w;
        py = 2 * ty * h;
      end
      MODE_ISO: begin
        px = (tx - ty) * w;
        py = (tx + ty) * h;
      end
      MODE_STAG: begin
        if (!c.axis) begin
          px = line_pos(tx, w, t.y[0], c.parity);
          py = ty * h;
        end else begin
          py = line_pos(ty, h, t.x[0], c.parity);
          px = tx * w;
        end
      end
      default: begin
        if (!c.axis) begin
          px = line_pos(tx, w, t.y[0], c.parity);
          py = ty * (h + s);
        end else begin
          py = line_pos(ty, h, t.x[0], c.parity);
          px = tx * (w + s);
        end
      end
    endcase
    r.x = px[OUT_W-1:0];
    r.y = py[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SIZE_W'($urandom_range(1, 15));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic add_tile(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    tile_t t;
    t.x = x;
    t.y = y;
    tiles_pending.insert(tiles_pending.size(), t);
  endtask

  task automatic drain();
    while (tiles_pending.size() != 0 || positions_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MODE:   regs.mode   = val[1:0];
      REG_AXIS:   regs.axis   = val[0];
      REG_PARITY: regs.parity = val[0];
      REG_WIDTH:  regs.width  = val;
      REG_HEIGHT: regs.height = val;
      REG_SIDE:   regs.side   = val;
      default: ;
    endcase
  endtask

  // The upper data bits of the narrow registers carry random junk, which must be ignored.
  task automatic configure(input logic [1:0] mode, input logic axis, input logic parity,
                           input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [SIZE_W-1:0] s);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MODE, {junk[CFG_DATA_W-1:2], mode});
    write_reg(REG_AXIS, {junk[CFG_DATA_W-1:1], axis});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_PARITY, {junk[CFG_DATA_W-1:1], parity});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_SIDE, s);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (tiles_pending.size() != 0 && (burst_left != 0 || $urandom_range(0, 99) >= idle_pct)) begin
      start  <= 1'b1;
      tile_x <= tiles_pending[0].x;
      tile_y <= tiles_pending[0].y;
    end else begin
      start  <= 1'b0;
      tile_x <= COORD_BITS'($urandom);
      tile_y <= COORD_BITS'($urandom);
    end
    if (burst_left != 0) begin
      burst_left = burst_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(8, 40);
    end
  end

  always @(posedge clk) begin
    pos_t  want;
    tile_t got_tile;
    if (!rst) begin
      if (done === 1'b1) begin
        if (positions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $error("unexpected transfer: pixel_x_half %0d, pixel_y_half %0d",
                   pixel_x_half, pixel_y_half);
        end else begin
          want = positions_due.pop_front();
          if (pixel_x_half !== want.x) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
              $error("pixel_x_half: expected %0d, got %0d", want.x, pixel_x_half);
          end
          if (pixel_y_half !== want.y) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
              $error("pixel_y_half: expected %0d, got %0d", want.y, pixel_y_half);
          end
        end
      end else if (done !== 1'b0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) $error("done: expected 0, got %b", done);
      end
      if (start && busy === 1'b0) begin
        got_tile.x = tile_x;
        got_tile.y = tile_y;
        positions_due.insert(positions_due.size(), project(got_tile, regs));
        void'(tiles_pending.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_tile('0, '0);
    add_tile('1, '1);

    configure(MODE_ORTHO, 1'b0, 1'b0, '1, '1, '0);
    add_tile('1, '1);
    add_tile('0, '1);
    add_tile('1, '0);

    configure(MODE_ISO, 1'b0, 1'b0, '1, '1, '0);
    add_tile('0, '1);
    add_tile('1, '0);
    add_tile('1, '1);

    configure(MODE_STAG, 1'b0, 1'b0, 10'd7, 10'd5, '0);
    add_tile(10'd3, 10'd0);
    add_tile(10'd3, 10'd1);

    configure(MODE_STAG, 1'b1, 1'b1, 10'd7, 10'd5, '0);
    add_tile(10'd0, 10'd3);
    add_tile(10'd1, 10'd3);

    // Hexagon side longer than the tile along the staggered axis.
    configure(MODE_HEX, 1'b0, 1'b1, 10'd9, 10'd2, '1);
    add_tile(10'd4, 10'd1022);
    add_tile(10'd4, '1);

    configure(MODE_HEX, 1'b1, 1'b0, 10'd2, 10'd9, '1);
    add_tile('1, 10'd4);
    add_tile(10'd1022, 10'd4);

    // Zero tile size gives no offset at all.
    configure(MODE_ISO, 1'b0, 1'b0, '0, '0, '0);
    add_tile('1, '0);
    add_tile(10'd5, 10'd9);

    configure(MODE_HEX, 1'b1, 1'b1, '1, '1, '1);
    add_tile('1, '1);
    add_tile('1, '0);

    for (int p = 0; p < PHASES; p++) begin
      configure(2'(p % 4), 1'($urandom), 1'($urandom), pick_size(), pick_size(), pick_size());
      if (p < PHASES / 3) idle_pct = 28;
      else if (p < 2 * PHASES / 3) idle_pct = 69;
      else idle_pct = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) add_tile(pick_coord(), pick_coord());
    end

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: tile_grid_to_pixel_position.f
design/tgp_pkg.sv
design/tgp_operand_sel.sv
design/tgp_mul_add.sv
design/tile_grid_to_pixel_position.sv
tb/tb.sv
